### src/hfnm_pkg.sv
// ----------------------------------------------------------------------------
// hfnm_pkg
// Shared constants, state types and a status struct for the raster hole filler.
// ----------------------------------------------------------------------------
package hfnm_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int CFG_INDEX_BITS = 3;
    localparam int COL_BITS       = 11;
    localparam int ROW_BITS       = 16;
    localparam int PEND_BITS      = 12;
    localparam int TOL_BITS       = 16;
    localparam int CUTOFF_BITS    = 4;
    localparam int COUNT_BITS     = 4;
    localparam int MIN_DIM        = 3;
    localparam int WIN_CELLS      = 9;
    localparam int WIN_CENTER     = 4;
    localparam int DIV_DIGITS     = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLE_VALUE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLE_TOLERANCE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEIGHBOR_CUTOFF = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT    = 3'd4;

    localparam logic [CUTOFF_BITS-1:0] RST_CUTOFF = 4'd5;
    localparam logic [COL_BITS-1:0]    RST_WIDTH  = 11'd1024;
    localparam logic [ROW_BITS-1:0]    RST_HEIGHT = 16'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDP,
        ST_PCAP,
        ST_RDA,
        ST_RDB,
        ST_SHIFT,
        ST_MEAN,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_FLAG,
        M_PAIR,
        M_SUM,
        M_LOAD,
        M_DIV,
        M_SIGN,
        M_DONE
    } mean_state_t;

    typedef struct packed {
        logic done;
        logic fill;
    } mean_status_t;

endpackage

### src/hfnm_line_mem.sv
// ----------------------------------------------------------------------------
// hfnm_line_mem
// Two-row line store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hfnm_line_mem #(
    parameter int ADDR_BITS = $clog2(hfnm_pkg::MAX_WIDTH_DEF) + 1,
    parameter int DATA_BITS = hfnm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/hfnm_mean.sv
// ----------------------------------------------------------------------------
// hfnm_mean
// Hole test over the 3x3 window, neighbor sum and count, and a digit-serial
// divide of the sum by the count, truncated toward zero.
// ----------------------------------------------------------------------------
module hfnm_mean #(
    parameter int SAMPLE_BITS = hfnm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [hfnm_pkg::WIN_CELLS-1:0][SAMPLE_BITS-1:0] win,
    input  logic [SAMPLE_BITS-1:0]                       hole_value,
    input  logic [hfnm_pkg::TOL_BITS-1:0]                hole_tol,
    input  logic [hfnm_pkg::CUTOFF_BITS-1:0]             cutoff,
    output hfnm_pkg::mean_status_t                       status,
    output logic [SAMPLE_BITS-1:0]                       mean
);

    localparam int SB        = SAMPLE_BITS;
    localparam int DIGITS    = hfnm_pkg::DIV_DIGITS;
    localparam int SUM_BITS  = SB + 3;
    localparam int DIV_STEPS = (SUM_BITS + DIGITS - 1) / DIGITS;
    localparam int DIV_BITS  = DIV_STEPS * DIGITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);
    localparam int NC        = hfnm_pkg::WIN_CELLS;
    localparam int CB        = hfnm_pkg::COUNT_BITS;

    hfnm_pkg::mean_state_t state_reg, state_next;

    logic [NC-1:0]             nh_reg;
    logic [3:0][SB:0]          pair_reg;
    logic [NC-1:0][SB:0]       masked;
    logic [CB-1:0]             num_reg;
    logic                      center_hole_reg;
    logic [SUM_BITS-1:0]       total_reg;
    logic                      fill_reg;
    logic                      neg_reg;
    logic [DIV_BITS-1:0]       quo_reg;
    logic [DIV_BITS-1:0]       quo_next;
    logic [3:0]                rem_reg;
    logic [3:0]                rem_next;
    logic [CNT_BITS-1:0]       cnt_reg;
    logic [SB-1:0]             mean_reg;
    logic [SUM_BITS-1:0]       magnitude;

    function automatic logic hole_test(input logic [SB-1:0] v,
                                       input logic [SB-1:0] hv,
                                       input logic [hfnm_pkg::TOL_BITS-1:0] tol);
        logic signed [SB:0] d;
        logic signed [SB:0] t;
        d = $signed({v[SB-1], v}) - $signed({hv[SB-1], hv});
        t = $signed((SB+1)'(tol));
        hole_test = (d <= t) && (d >= -t);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hfnm_pkg::M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hfnm_pkg::M_IDLE: if (start) state_next = hfnm_pkg::M_FLAG;
            hfnm_pkg::M_FLAG: state_next = hfnm_pkg::M_PAIR;
            hfnm_pkg::M_PAIR: state_next = hfnm_pkg::M_SUM;
            hfnm_pkg::M_SUM:  state_next = hfnm_pkg::M_LOAD;
            hfnm_pkg::M_LOAD: state_next = fill_reg ? hfnm_pkg::M_DIV : hfnm_pkg::M_DONE;
            hfnm_pkg::M_DIV:  if (cnt_reg == '0) state_next = hfnm_pkg::M_SIGN;
            hfnm_pkg::M_SIGN: state_next = hfnm_pkg::M_DONE;
            hfnm_pkg::M_DONE: state_next = hfnm_pkg::M_IDLE;
            default:          state_next = hfnm_pkg::M_IDLE;
        endcase
        status.done = (state_reg == hfnm_pkg::M_DONE);
        status.fill = fill_reg;
    end

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            masked[k] = nh_reg[k] ? {win[k][SB-1], win[k]} : '0;
        end
    end

    assign magnitude = total_reg[SUM_BITS-1] ? (~total_reg + 1'b1) : total_reg;

    // restoring divide, one quotient digit per step
    always_comb
    begin
        logic [3:0]          r;
        logic [3:0]          t;
        logic [DIV_BITS-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            t = {r[2:0], q[DIV_BITS-1]};
            q = {q[DIV_BITS-2:0], 1'b0};
            if (t >= num_reg)
            begin
                t    = t - num_reg;
                q[0] = 1'b1;
            end
            r = t;
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            hfnm_pkg::M_FLAG:
            begin
                for (int k = 0; k < NC; k++)
                begin
                    nh_reg[k] <= !hole_test(win[k], hole_value, hole_tol);
                end
            end
            hfnm_pkg::M_PAIR:
            begin
                pair_reg[0]     <= masked[0] + masked[1];
                pair_reg[1]     <= masked[2] + masked[3];
                pair_reg[2]     <= masked[5] + masked[6];
                pair_reg[3]     <= masked[7] + masked[8];
                num_reg         <= CB'($countones({nh_reg[8:5], nh_reg[3:0]}));
                center_hole_reg <= !nh_reg[hfnm_pkg::WIN_CENTER];
            end
            hfnm_pkg::M_SUM:
            begin
                total_reg <= {{2{pair_reg[0][SB]}}, pair_reg[0]}
                           + {{2{pair_reg[1][SB]}}, pair_reg[1]}
                           + {{2{pair_reg[2][SB]}}, pair_reg[2]}
                           + {{2{pair_reg[3][SB]}}, pair_reg[3]};
                fill_reg  <= center_hole_reg && (num_reg > cutoff);
            end
            hfnm_pkg::M_LOAD:
            begin
                neg_reg <= total_reg[SUM_BITS-1];
                quo_reg <= DIV_BITS'(magnitude);
                rem_reg <= '0;
                cnt_reg <= CNT_BITS'(DIV_STEPS - 1);
            end
            hfnm_pkg::M_DIV:
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
            end
            hfnm_pkg::M_SIGN:
            begin
                mean_reg <= neg_reg ? SB'(~quo_reg + 1'b1) : SB'(quo_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign mean = mean_reg;

endmodule

### src/raster_hole_fill_neighbor_mean_top.sv
// ----------------------------------------------------------------------------
// raster_hole_fill_neighbor_mean_top
// In-place raster hole filler: two-row line store, 3x3 window, neighbor mean.
// ----------------------------------------------------------------------------
// Flow: a request is taken only in the idle state, so a new request waits until
//   the previous one is done; a held result register stalls the next result;
//   the mean unit sets the interior rate.
// Reset: registers return to their defaults, counters and window clear at once;
//   the line store is left as is and needs no clearing pass.
module raster_hole_fill_neighbor_mean_top #(
    parameter int MAX_WIDTH   = hfnm_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = hfnm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [hfnm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [SAMPLE_BITS-1:0]               cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_BITS-1:0]        sample_out,
    output logic                                 was_filled,
    output logic                                 last_of_frame
);

    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int AW  = CW + 1;
    localparam int WB  = hfnm_pkg::COL_BITS;
    localparam int HB  = hfnm_pkg::ROW_BITS;
    localparam int PB  = hfnm_pkg::PEND_BITS;
    localparam int CTR = hfnm_pkg::WIN_CENTER;

    hfnm_pkg::top_state_t state_reg, state_next;

    logic [SB-1:0]                   hole_value_reg;
    logic [hfnm_pkg::TOL_BITS-1:0]   hole_tol_reg;
    logic [hfnm_pkg::CUTOFF_BITS-1:0] cutoff_reg;
    logic [WB-1:0]                   width_reg;
    logic [HB-1:0]                   height_reg;

    logic [WB-1:0]  col_reg;
    logic [HB-1:0]  row_reg;
    logic [PB-1:0]  pend_reg;
    logic           act_reg;
    logic           emit_reg;
    logic           pro_reg;
    logic           filled_reg;
    logic           out_valid_reg;
    logic [hfnm_pkg::WIN_CELLS-1:0][SB-1:0] win_reg;

    logic [SB-1:0]  x_reg;
    logic [SB-1:0]  a_reg;
    logic [SB-1:0]  pdata_reg;
    logic signed [SB-1:0] sample_out_reg;
    logic           was_filled_reg;
    logic           last_reg;

    logic [WB-1:0]  w_eff;
    logic [HB-1:0]  h_eff;
    logic [PB-1:0]  w_plus1;
    logic [WB-1:0]  c_sat;
    logic [HB-1:0]  r_sat;
    logic           prologue_in;
    logic [PB-1:0]  due;
    logic           accept;
    logic           drain_ok;
    logic           push_emit;
    logic [AW-1:0]  paddr;
    logic           need_out;
    logic           out_go;
    logic [PB-1:0]  pend_dec;
    logic           mean_start;
    logic           col_last;
    logic           row_last;
    logic           frame_end;

    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    logic [SB-1:0]  mem_wr_data;
    logic           mem_rd_en;
    logic [AW-1:0]  mem_rd_addr;
    logic [SB-1:0]  mem_rd_data;

    hfnm_pkg::mean_status_t mstat;
    logic [SB-1:0]          mean_val;

    always_comb
    begin
        if (width_reg < WB'(hfnm_pkg::MIN_DIM))
        begin
            w_eff = WB'(hfnm_pkg::MIN_DIM);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < HB'(hfnm_pkg::MIN_DIM)) ? HB'(hfnm_pkg::MIN_DIM) : height_reg;
    end

    assign w_plus1     = {1'b0, w_eff} + 1'b1;
    assign c_sat       = (col_reg >= w_eff) ? (w_eff - 1'b1) : col_reg;
    assign r_sat       = (row_reg >= h_eff) ? (h_eff - 1'b1) : row_reg;
    assign prologue_in = (r_sat == '0) || ((r_sat == HB'(1)) && (c_sat == '0));
    assign due         = (r_sat == '0) ? (w_plus1 - {1'b0, c_sat}) : PB'(1);
    assign accept      = in_valid && in_ready;
    assign drain_ok    = (r_sat == '0) && (c_sat == '0) && (pend_reg != '0);
    assign push_emit   = prologue_in && (pend_reg != '0) && (pend_reg == due);
    assign paddr       = (pend_reg >= w_plus1)
                       ? {h_eff[0], CW'(w_eff - 1'b1)}
                       : {~h_eff[0], CW'(w_eff - pend_reg[WB-1:0])};
    assign need_out    = emit_reg || (!act_reg && !pro_reg);
    assign out_go      = !need_out || !out_valid_reg || out_ready;
    assign pend_dec    = emit_reg ? (pend_reg - 1'b1) : pend_reg;
    assign mean_start  = (state_reg == hfnm_pkg::ST_SHIFT)
                       && (col_reg >= WB'(2)) && (row_reg >= HB'(2));
    assign col_last    = (({1'b0, col_reg} + 1'b1) >= {1'b0, w_eff});
    assign row_last    = (({1'b0, row_reg} + 1'b1) >= {1'b0, h_eff});
    assign frame_end   = !act_reg && col_last && row_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hfnm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = x_reg;
        case (state_reg)
            hfnm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (action)
                    begin
                        state_next = drain_ok ? hfnm_pkg::ST_RDP : hfnm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = push_emit ? hfnm_pkg::ST_RDP : hfnm_pkg::ST_RDA;
                    end
                end
            end
            hfnm_pkg::ST_RDP:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = paddr;
                state_next  = hfnm_pkg::ST_PCAP;
            end
            hfnm_pkg::ST_PCAP:
            begin
                state_next = act_reg ? hfnm_pkg::ST_OUT : hfnm_pkg::ST_RDA;
            end
            hfnm_pkg::ST_RDA:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {row_reg[0], CW'(col_reg)};
                state_next  = hfnm_pkg::ST_RDB;
            end
            hfnm_pkg::ST_RDB:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {~row_reg[0], CW'(col_reg)};
                mem_wr_en   = 1'b1;
                mem_wr_addr = {row_reg[0], CW'(col_reg)};
                mem_wr_data = x_reg;
                state_next  = hfnm_pkg::ST_SHIFT;
            end
            hfnm_pkg::ST_SHIFT:
            begin
                state_next = mean_start ? hfnm_pkg::ST_MEAN : hfnm_pkg::ST_OUT;
            end
            hfnm_pkg::ST_MEAN:
            begin
                if (mstat.done)
                begin
                    mem_wr_en   = mstat.fill;
                    mem_wr_addr = {~row_reg[0], CW'(col_reg - 1'b1)};
                    mem_wr_data = mean_val;
                    state_next  = hfnm_pkg::ST_OUT;
                end
            end
            hfnm_pkg::ST_OUT:
            begin
                if (out_go)
                begin
                    state_next = hfnm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hfnm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_value_reg <= '0;
            hole_tol_reg   <= '0;
            cutoff_reg     <= hfnm_pkg::RST_CUTOFF;
            width_reg      <= hfnm_pkg::RST_WIDTH;
            height_reg     <= hfnm_pkg::RST_HEIGHT;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_reg       <= '0;
            act_reg        <= 1'b0;
            emit_reg       <= 1'b0;
            pro_reg        <= 1'b0;
            filled_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            win_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    hfnm_pkg::CFG_HOLE_VALUE:      hole_value_reg <= cfg_data;
                    hfnm_pkg::CFG_HOLE_TOLERANCE:  hole_tol_reg   <= cfg_data[15:0];
                    hfnm_pkg::CFG_NEIGHBOR_CUTOFF: cutoff_reg     <= cfg_data[3:0];
                    hfnm_pkg::CFG_IMAGE_WIDTH:     width_reg      <= cfg_data[10:0];
                    hfnm_pkg::CFG_IMAGE_HEIGHT:    height_reg     <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end

            if ((state_reg == hfnm_pkg::ST_OUT) && out_go && need_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                hfnm_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg    <= action;
                        col_reg    <= c_sat;
                        row_reg    <= r_sat;
                        pro_reg    <= prologue_in;
                        filled_reg <= 1'b0;
                        if (action)
                        begin
                            emit_reg <= drain_ok;
                            if (drain_ok && (pend_reg > w_plus1))
                            begin
                                pend_reg <= w_plus1;
                            end
                        end
                        else
                        begin
                            emit_reg <= push_emit;
                            if (!push_emit)
                            begin
                                pend_reg <= '0;
                            end
                        end
                    end
                end
                hfnm_pkg::ST_SHIFT:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        win_reg[a*3]     <= win_reg[a*3 + 1];
                        win_reg[a*3 + 1] <= win_reg[a*3 + 2];
                    end
                    win_reg[2] <= a_reg;
                    win_reg[5] <= mem_rd_data;
                    win_reg[8] <= x_reg;
                end
                hfnm_pkg::ST_MEAN:
                begin
                    if (mstat.done && mstat.fill)
                    begin
                        win_reg[CTR] <= mean_val;
                        filled_reg   <= 1'b1;
                    end
                end
                hfnm_pkg::ST_OUT:
                begin
                    if (out_go)
                    begin
                        pend_reg <= frame_end ? w_plus1 : pend_dec;
                        if (!act_reg)
                        begin
                            if (col_last)
                            begin
                                col_reg <= '0;
                                if (row_last)
                                begin
                                    row_reg <= '0;
                                end
                                else
                                begin
                                    row_reg <= row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_reg <= col_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample_in;
        end
        if (state_reg == hfnm_pkg::ST_PCAP)
        begin
            pdata_reg <= mem_rd_data;
        end
        if (state_reg == hfnm_pkg::ST_RDB)
        begin
            a_reg <= mem_rd_data;
        end
        if ((state_reg == hfnm_pkg::ST_OUT) && out_go && need_out)
        begin
            if (emit_reg)
            begin
                sample_out_reg <= pdata_reg;
                was_filled_reg <= 1'b0;
                last_reg       <= (pend_reg == PB'(1));
            end
            else
            begin
                sample_out_reg <= win_reg[CTR];
                was_filled_reg <= filled_reg;
                last_reg       <= 1'b0;
            end
        end
    end

    hfnm_line_mem #(
        .ADDR_BITS (AW),
        .DATA_BITS (SB)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    hfnm_mean #(
        .SAMPLE_BITS (SB)
    ) u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mean_start),
        .win        (win_reg),
        .hole_value (hole_value_reg),
        .hole_tol   (hole_tol_reg),
        .cutoff     (cutoff_reg),
        .status     (mstat),
        .mean       (mean_val)
    );

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign was_filled    = was_filled_reg;
    assign last_of_frame = last_reg;

endmodule

### src/hfnm_checker.sv
// ----------------------------------------------------------------------------
// hfnm_checker
// Port-level checks for the raster hole filler, bound to the top level.
// ----------------------------------------------------------------------------
module hfnm_checker #(
    parameter int SAMPLE_BITS = hfnm_pkg::SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   action,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic                   was_filled,
    input logic                   last_of_frame
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out))
        else $error("result payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_filled && last_of_frame))
        else $error("frame tail sample flagged as filled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !action |=> !in_ready)
        else $error("push request did not occupy the block");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a request in flight");

endmodule

bind raster_hole_fill_neighbor_mean_top hfnm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_hfnm_checker (.*);

### dv/raster_hole_fill_neighbor_mean_top_tb.sv
// ----------------------------------------------------------------------------
// raster_hole_fill_neighbor_mean_top_tb
// Drives whole raster frames of Q16.16 samples into the hole filler, with
// drains, early next-frame pushes and a few broken frames. Every accepted
// request is run through a behavioral copy of the filler, and every output
// sample is compared against the oldest expected sample.
// ----------------------------------------------------------------------------
module raster_hole_fill_neighbor_mean_top_tb;

    localparam int MAXW = hfnm_pkg::MAX_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic signed [31:0] value;
        logic               filled;
        logic               last;
    } px_t;

    typedef struct {
        logic               act;
        logic signed [31:0] smp;
        logic               chk;
        px_t                px;
        logic               has_px;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [hfnm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic action;
    logic signed [31:0] sample_in;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] sample_out;
    logic was_filled;
    logic last_of_frame;

    raster_hole_fill_neighbor_mean_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .sample_in(sample_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample_out(sample_out), .was_filled(was_filled),
        .last_of_frame(last_of_frame)
    );

    logic signed [31:0] m_hole;
    logic [15:0] m_tol;
    logic [3:0]  m_cutoff;
    logic [10:0] m_width;
    logic [15:0] m_height;
    logic signed [31:0] m_lines [0:2*MAXW-1];
    logic signed [31:0] m_win [0:2][0:2];
    int unsigned m_col;
    int unsigned m_row;
    int unsigned m_pend;

    px_t pixel_q [$];
    int  errors;
    int  idle_cycles;
    bit  hold_long;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_w();
        if (m_width < 3) return 3;
        if (m_width > MAXW) return MAXW;
        return m_width;
    endfunction

    function automatic int unsigned eff_h();
        return (m_height < 3) ? 3 : m_height;
    endfunction

    function automatic bit hole_match(logic signed [31:0] v);
        longint d;
        d = longint'(v) - longint'(m_hole);
        if (d < 0) d = -d;
        return d <= longint'(m_tol);
    endfunction

    function automatic logic signed [31:0] pending_px(int unsigned n, int unsigned w,
                                                     int unsigned h);
        if (n >= w + 1) return m_lines[((h - 2) & 1) * MAXW + (w - 1)];
        return m_lines[((h - 1) & 1) * MAXW + (w - n)];
    endfunction

    task automatic model_reset();
        m_hole = 0;
        m_tol = 0;
        m_cutoff = 5;
        m_width = 1024;
        m_height = 1024;
        for (int i = 0; i < 2 * MAXW; i++) m_lines[i] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m_win[i][j] = 0;
        m_col = 0;
        m_row = 0;
        m_pend = 0;
    endtask

    task automatic model_cfg(logic [hfnm_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
        case (idx)
            hfnm_pkg::CFG_HOLE_VALUE:      m_hole = val;
            hfnm_pkg::CFG_HOLE_TOLERANCE:  m_tol = val[15:0];
            hfnm_pkg::CFG_NEIGHBOR_CUTOFF: m_cutoff = val[3:0];
            hfnm_pkg::CFG_IMAGE_WIDTH:     m_width = val[10:0];
            hfnm_pkg::CFG_IMAGE_HEIGHT:    m_height = val[15:0];
            default: ;
        endcase
    endtask

    // Returns 1 and fills px when the request yields an output sample.
    function automatic bit fill_step(logic act, logic signed [31:0] x, output px_t px);
        int unsigned w, h, r, c, due;
        bit prologue;
        bit got;
        longint sum, num;
        px = '0;
        got = 0;
        w = eff_w();
        h = eff_h();
        if (m_col >= w) m_col = w - 1;
        if (m_row >= h) m_row = h - 1;
        r = m_row;
        c = m_col;
        if (act == ACT_DRAIN)
        begin
            if (r != 0 || c != 0 || m_pend == 0) return 0;
            if (m_pend > w + 1) m_pend = w + 1;
            px.value = pending_px(m_pend, w, h);
            px.last = (m_pend == 1);
            m_pend--;
            return 1;
        end
        prologue = (r == 0) || (r == 1 && c == 0);
        if (prologue)
        begin
            due = w + 1 - ((r == 0) ? c : w);
            if (m_pend != 0 && m_pend == due)
            begin
                px.value = pending_px(m_pend, w, h);
                px.last = (m_pend == 1);
                m_pend--;
                got = 1;
            end
            else
            begin
                m_pend = 0;
            end
        end
        else
        begin
            m_pend = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            m_win[i][0] = m_win[i][1];
            m_win[i][1] = m_win[i][2];
        end
        m_win[0][2] = m_lines[(r & 1) * MAXW + c];
        m_win[1][2] = m_lines[((r + 1) & 1) * MAXW + c];
        m_win[2][2] = x;
        m_lines[(r & 1) * MAXW + c] = x;
        if (!prologue)
        begin
            px.filled = 0;
            px.last = 0;
            if (c >= 2 && r >= 2 && r <= h - 1 && hole_match(m_win[1][1]))
            begin
                sum = 0;
                num = 0;
                for (int a = 0; a < 3; a++)
                    for (int b = 0; b < 3; b++)
                        if (!(a == 1 && b == 1) && !hole_match(m_win[a][b]))
                        begin
                            sum += longint'(m_win[a][b]);
                            num++;
                        end
                if (num > longint'(m_cutoff))
                begin
                    m_win[1][1] = 32'(sum / num);
                    m_lines[((r + 1) & 1) * MAXW + (c - 1)] = m_win[1][1];
                    px.filled = 1;
                end
            end
            px.value = m_win[1][1];
            got = 1;
        end
        if (c + 1 >= w)
        begin
            m_col = 0;
            if (r + 1 >= h)
            begin
                m_row = 0;
                m_pend = w + 1;
            end
            else
            begin
                m_row = r + 1;
            end
        end
        else
        begin
            m_col = c + 1;
        end
        return got;
    endfunction

    task automatic send_req(logic act, logic signed [31:0] x, output bit got,
                            output px_t px);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        sample_in <= x;
        do @(posedge clk); while (!in_ready);
        got = fill_step(act, x, px);
        if (got) pixel_q.push_back(px);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic cfg_write(logic [hfnm_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_cfg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_pixel(logic signed [31:0] hv);
        case ($urandom_range(0, 5))
            0, 1: return hv + $signed(32'($urandom_range(0, 2 * m_tol + 2))) - m_tol - 1;
            2:    return $urandom;
            3:    return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 32'h00ff_ffff))) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic set_geometry(int w, int h);
        cfg_write(hfnm_pkg::CFG_IMAGE_WIDTH, w);
        cfg_write(hfnm_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    initial
    begin
        row_t dir [$];
        row_t rw;
        bit got;
        px_t px;
        int n;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = hfnm_pkg::CFG_HOLE_VALUE;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_PUSH;
        sample_in = '0;
        errors = 0;
        hold_long = 0;
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drain right after reset has nothing pending.
        rw = '{ACT_DRAIN, 0, 1'b1, '0, 1'b0};
        dir.push_back(rw);

        // 3x3 frame with extremes and a hole at the center, then drains.
        for (int i = 0; i < 9; i++)
        begin
            rw.act = ACT_PUSH;
            rw.smp = (i == 4) ? 32'sh80000000 : ((i & 1) ? 32'sh7fffffff : 32'sh7ffffff0);
            rw.chk = (i == 8);
            rw.px = '{32'sh7ffffff7, 1'b1, 1'b0};
            rw.has_px = 1'b1;
            dir.push_back(rw);
        end
        for (int i = 0; i < 6; i++)
        begin
            rw.act = ACT_DRAIN;
            rw.smp = 0;
            rw.chk = (i >= 3);
            rw.px = '{32'sh7ffffff0, 1'b0, 1'b1};
            rw.has_px = (i == 3);
            dir.push_back(rw);
        end

        foreach (dir[i])
        begin
            if (i == 1)
            begin
                wait_drained();
                set_geometry(3, 3);
                cfg_write(hfnm_pkg::CFG_HOLE_VALUE, 32'sh80000000);
                cfg_write(hfnm_pkg::CFG_HOLE_TOLERANCE, 0);
                cfg_write(hfnm_pkg::CFG_NEIGHBOR_CUTOFF, 0);
            end
            send_req(dir[i].act, dir[i].smp, got, px);
            if (dir[i].chk && ((got != dir[i].has_px) || (got && (px !== dir[i].px))))
            begin
                $display("%0t: directed row %0d expected %b %h actual %b %h", $time, i,
                         dir[i].has_px, dir[i].px, got, px);
                errors++;
            end
        end
        wait_drained();

        // Random frames over several register settings.
        n = 0;
        while (n < 1550)
        begin
            logic signed [31:0] hv;
            int w, h, mode;
            case ($urandom_range(0, 4))
                0: hv = 0;
                1: hv = 32'sh7fffffff;
                2: hv = 32'sh80000000;
                default: hv = $urandom;
            endcase
            cfg_write(hfnm_pkg::CFG_HOLE_VALUE, hv);
            cfg_write(hfnm_pkg::CFG_HOLE_TOLERANCE, ($urandom_range(0, 3) == 0) ? 16'hffff
                                                    : $urandom_range(0, 300));
            cfg_write(hfnm_pkg::CFG_NEIGHBOR_CUTOFF, ($urandom_range(0, 5) == 0) ? 15
                                                     : $urandom_range(0, 8));
            if ($urandom_range(0, 15) == 0)
            begin
                w = $urandom_range(13, 40);
                h = $urandom_range(0, 2);
            end
            else
            begin
                w = $urandom_range(0, 6) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12);
                h = $urandom_range(0, 6) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
            end
            set_geometry(w, h);
            w = eff_w();
            h = eff_h();
            if (n > 300 && !hold_long && w < 40) hold_long = 1;
            repeat ($urandom_range(1, 3))
            begin
                mode = $urandom_range(0, 9);
                for (int i = 0; i < w * h; i++)
                begin
                    if (mode == 0 && i > 1 && $urandom_range(0, 9) == 0) break;
                    if ($urandom_range(0, 40) == 0) send_req(ACT_DRAIN, $urandom, got, px);
                    send_req(ACT_PUSH, rand_pixel(hv), got, px);
                    n++;
                end
                if (mode < 6)
                begin
                    int k;
                    k = (mode == 1) ? $urandom_range(0, w + 3) : w + 3;
                    repeat (k)
                    begin
                        send_req(ACT_DRAIN, $urandom, got, px);
                        n++;
                    end
                end
            end
            // Flush whatever was left so the next geometry starts clean.
            repeat (w + 2) send_req(ACT_DRAIN, 0, got, px);
            if (m_row != 0 || m_col != 0)
            begin
                while (m_row != 0 || m_col != 0)
                begin
                    send_req(ACT_PUSH, 0, got, px);
                    n++;
                end
                repeat (w + 2) send_req(ACT_DRAIN, 0, got, px);
            end
            wait_drained();
        end
        wait_drained();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off.
    initial
    begin
        bit held;
        int k;
        held = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long && !held)
            begin
                held = 1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            if (k != 0)
            begin
                out_ready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        px_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("%0t: unexpected sample expected none actual %h", $time, sample_out);
                errors++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (sample_out !== want.value)
                begin
                    $display("%0t: sample_out expected %h actual %h", $time, want.value,
                             sample_out);
                    errors++;
                end
                if (was_filled !== want.filled)
                begin
                    $display("%0t: was_filled expected %b actual %b", $time, want.filled,
                             was_filled);
                    errors++;
                end
                if (last_of_frame !== want.last)
                begin
                    $display("%0t: last_of_frame expected %b actual %b", $time, want.last,
                             last_of_frame);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
